FILE: rtl/uvs_pkg.sv
// Package for the UV sphere tessellator: field widths, register indexes,
// sine coefficients and the default parameters shared by the pipeline cells.
`default_nettype none
package uvs_pkg;
    localparam int MAX_SEGMENTS_DEF    = 1024;
    localparam int COORD_FRAC_BITS_DEF = 14;
    localparam int CNT_W   = 11;
    localparam int COORD_W = 16;
    localparam int TEX_W   = 17;
    localparam int IDX_W   = 21;
    localparam int PH_W    = 32;
    localparam int Q_W     = 31;   // Q30 magnitude up to 1.0

    localparam logic [CNT_W-1:0] REG_LAT = 11'd0;
    localparam logic [CNT_W-1:0] REG_LON = 11'd1;

    localparam logic [Q_W-1:0] COEF0 = 31'd1686629713;
    localparam logic [Q_W-1:0] COEF1 = 31'd693598668;
    localparam logic [Q_W-1:0] COEF2 = 31'd85569306;
    localparam logic [Q_W-1:0] COEF3 = 31'd5026995;
    localparam logic [Q_W-1:0] COEF4 = 31'd172272;
endpackage
`default_nettype wire

FILE: rtl/uvs_div_cell.sv
// One restoring-division cell: retires one quotient bit per stage.
// Depends on nothing; used in the divider rows of the tessellator.
`default_nettype none
module uvs_div_cell #(
    parameter int NW = 44,
    parameter int DW = 12
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num_in,
    input  wire logic [DW-1:0] rem_in,
    input  wire logic [DW-1:0] den,
    output logic      [NW-1:0] num_out,
    output logic      [DW-1:0] rem_out
);
    logic [DW:0]   trial;
    logic          fits;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] num_next;

    always_comb begin
        trial    = {rem_in, num_in[NW-1]};
        fits     = trial >= {1'b0, den};
        rem_next = fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
        num_next = {num_in[NW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_out <= num_next;
            rem_out <= rem_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/uvs_sine_cell.sv
// One Horner step of the quarter-wave sine polynomial: p' = c - (p*x2 >> 30).
// Depends on uvs_pkg.
`default_nettype none
module uvs_sine_cell (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [uvs_pkg::Q_W-1:0] coef,
    input  wire logic [uvs_pkg::Q_W-1:0] p_in,
    input  wire logic [uvs_pkg::Q_W-1:0] x2_in,
    output logic      [uvs_pkg::Q_W-1:0] p_out
);
    import uvs_pkg::*;
    logic [2*Q_W-1:0] prod;
    always_comb prod = p_in * x2_in;
    always_ff @(posedge aclk) begin
        if (en) p_out <= Q_W'(coef - prod[2*Q_W-1:30]);
    end
endmodule
`default_nettype wire

FILE: rtl/uv_sphere_tessellator.sv
// Top level of the UV sphere tessellator: stream in, pipeline of divider and
// sine cells, stream out. Depends on uvs_pkg, uvs_div_cell, uvs_sine_cell.
//
//  channel   direction  tdata fields (low bit up)
//  s_axis    in         row[10:0], col[21:11]
//  m_axis    out        pos_x, pos_y, pos_z, tex_u, tex_v, idx_tl, idx_tr,
//                       idx_bl, idx_br (tuser: has_quad, out_of_range)
//  cfg       in         cfg_addr selects lat_segments(0) / lon_segments(1)
//
// One beat per cycle while the output stage is empty or taken; the pipeline is a capture
// stage, 44-cell divider rows (one quotient bit per cell), six sine stages, product
// stage and output register.
// Synchronous active-low reset clears the valid chain; payload is not reset.
// The whole pipeline advances when the output stage is empty or taken.
`default_nettype none
module uv_sphere_tessellator #(
    parameter int MAX_SEGMENTS    = uvs_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_FRAC_BITS = uvs_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [23:0]  s_axis_tdata,   // row, col, zero pad
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [167:0]      m_axis_tdata,   // pos_x,pos_y,pos_z,tex_u,tex_v,idx x4
    output logic [1:0]        m_axis_tuser,   // has_quad, out_of_range
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [10:0]  cfg_addr,
    input  wire logic [10:0]  cfg_data
);
    import uvs_pkg::*;
    localparam int NW  = 44;          // numerator: 11 int bits + 32 frac + spare
    localparam int DW  = 13;          // divisor up to 2*MAX
    localparam int ND  = 44;          // division cells
    localparam int NS  = 6;           // sine cells (x2 + 4 Horner + final)
    localparam int PIPE = 1 + ND + NS + 2;
    localparam int TEX_DLY = NS + 1;  // texture quotients wait for the products

    logic [CNT_W-1:0] lat_reg, lon_reg;
    logic [CNT_W-1:0] lat_c, lon_c;
    logic             adv;
    logic [PIPE-1:0]  vld_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lat_reg <= 11'd16;
            lon_reg <= 11'd32;
        end else if (cfg_valid) begin
            if (cfg_addr == REG_LAT) lat_reg <= cfg_data;
            else if (cfg_addr == REG_LON) lon_reg <= cfg_data;
        end
    end
    always_comb begin
        lat_c = (lat_reg == '0) ? 11'd1 :
                (32'(lat_reg) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : lat_reg;
        lon_c = (lon_reg == '0) ? 11'd1 :
                (32'(lon_reg) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS) : lon_reg;
    end

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[PIPE-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = vld_reg[PIPE-1];

    // stage 0: capture, range check, indexes
    typedef struct packed {
        logic [CNT_W-1:0] row, col, lat, lon;
        logic             oor, quad;
        logic [IDX_W-1:0] tl;
    } side_t;
    side_t side_pipe [PIPE];
    logic [NW-1:0] nt0, np0, nut0, nuv0;
    logic [DW-1:0] dt0, dp0;
    side_t s0;
    logic [CNT_W-1:0] row_i, col_i;
    logic [2*CNT_W:0] tl_w;
    assign row_i = s_axis_tdata[10:0];
    assign col_i = s_axis_tdata[21:11];
    always_comb begin
        s0.row = row_i; s0.col = col_i; s0.lat = lat_c; s0.lon = lon_c;
        s0.oor  = (row_i > lat_c) || (col_i > lon_c);
        s0.quad = (row_i < lat_c) && (col_i < lon_c);
        tl_w = 23'(row_i) * (23'(lon_c) + 23'd1) + 23'(col_i);
        s0.tl = tl_w[IDX_W-1:0];
    end
    always_ff @(posedge aclk) if (adv) side_pipe[0] <= s0;
    for (genvar g = 1; g < PIPE; g++) begin : g_side
        always_ff @(posedge aclk) if (adv) side_pipe[g] <= side_pipe[g-1];
    end

    // stage 1 operands from registered side info
    side_t a;
    assign a = side_pipe[0];
    always_comb begin
        nt0  = {1'b0, a.row, 32'd0} + NW'(a.lat);
        dt0  = {1'b0, a.lat, 1'b0};
        np0  = {1'b0, a.col, 32'd0} + NW'(a.lon >> 1);
        dp0  = DW'(a.lon);
        nuv0 = NW'({a.row, 16'd0}) + NW'(a.lat >> 1);
        nut0 = NW'({a.col, 16'd0}) + NW'(a.lon >> 1);
    end

    // four divider rows; the texture rows reuse the same depth
    logic [NW-1:0] qn [4][ND+1];
    logic [DW-1:0] qr [4][ND+1];
    logic [DW-1:0] dv [4][ND+1];
    assign qn[0][0] = nt0;  assign qr[0][0] = '0; assign dv[0][0] = dt0;
    assign qn[1][0] = np0;  assign qr[1][0] = '0; assign dv[1][0] = dp0;
    assign qn[2][0] = nut0; assign qr[2][0] = '0; assign dv[2][0] = dp0;
    assign qn[3][0] = nuv0; assign qr[3][0] = '0; assign dv[3][0] = DW'(a.lat);
    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < ND; c++) begin : g_cell
            uvs_div_cell #(.NW(NW), .DW(DW)) u_cell (
                .aclk(aclk), .en(adv), .num_in(qn[r][c]), .rem_in(qr[r][c]),
                .den(dv[r][c]), .num_out(qn[r][c+1]), .rem_out(qr[r][c+1]));
            always_ff @(posedge aclk) if (adv) dv[r][c+1] <= dv[r][c];
        end
    end

    // quarter-wave arguments for st, ct, sp, cp
    logic [PH_W-1:0] ph [4];
    logic [Q_W-1:0]  xq [4];
    logic [3:0]      sgn;
    assign ph[0] = qn[0][ND][PH_W-1:0];
    assign ph[1] = ph[0] + 32'h4000_0000;
    assign ph[2] = qn[1][ND][PH_W-1:0];
    assign ph[3] = ph[2] + 32'h4000_0000;
    for (genvar k = 0; k < 4; k++) begin : g_arg
        assign xq[k] = ph[k][30] ? (31'h4000_0000 - {1'b0, ph[k][29:0]})
                                 : {1'b0, ph[k][29:0]};
        assign sgn[k] = ph[k][31];
    end

    // sine cells: x2, four Horner steps, final product
    logic [Q_W-1:0] x_s [4][NS-1];
    logic [Q_W-1:0] x2_s [4][NS-1];
    logic [Q_W-1:0] p_s [4][NS-1];
    logic [3:0]     sg_s [NS];
    logic [2*Q_W-1:0] sq [4];
    logic [Q_W-1:0] cf [4];
    assign cf[0] = COEF3; assign cf[1] = COEF2; assign cf[2] = COEF1; assign cf[3] = COEF0;
    for (genvar k = 0; k < 4; k++) begin : g_sin
        assign sq[k] = xq[k] * xq[k];
        always_ff @(posedge aclk) if (adv) begin
            x_s[k][0]  <= xq[k];
            x2_s[k][0] <= sq[k][2*Q_W-2:30];
            p_s[k][0]  <= COEF4;
        end
        for (genvar h = 0; h < 4; h++) begin : g_h
            uvs_sine_cell u_h (.aclk(aclk), .en(adv), .coef(cf[h]),
                .p_in(p_s[k][h]), .x2_in(x2_s[k][h]), .p_out(p_s[k][h+1]));
            always_ff @(posedge aclk) if (adv) begin
                x_s[k][h+1]  <= x_s[k][h];
                x2_s[k][h+1] <= x2_s[k][h];
            end
        end
    end
    always_ff @(posedge aclk) if (adv) sg_s[0] <= sgn;
    for (genvar h = 1; h < 5; h++) begin : g_sg
        always_ff @(posedge aclk) if (adv) sg_s[h] <= sg_s[h-1];
    end
    // final s = p*x >> 30, clamp
    logic [Q_W-1:0] mag [4];
    logic [3:0]     neg;
    logic [2*Q_W-1:0] fp [4];
    for (genvar k = 0; k < 4; k++) begin : g_fin
        assign fp[k] = p_s[k][4] * x_s[k][4];
        always_ff @(posedge aclk) if (adv) begin
            mag[k] <= (fp[k][2*Q_W-1:30] > 32'h4000_0000) ? 31'h4000_0000
                                                          : Q_W'(fp[k][2*Q_W-1:30]);
        end
    end
    always_ff @(posedge aclk) if (adv) sg_s[5] <= sg_s[4];
    for (genvar k = 0; k < 4; k++) begin : g_neg
        assign neg[k] = sg_s[5][k] && (mag[k] != '0);
    end

    // products to Q60
    logic [2*Q_W-1:0] px, pz, py;
    logic nx, ny, nz;
    always_ff @(posedge aclk) if (adv) begin
        px <= mag[0] * mag[3];
        pz <= mag[0] * mag[2];
        py <= {1'b0, mag[1], 30'd0};
        nx <= neg[0] != neg[3];
        nz <= neg[0] != neg[2];
        ny <= neg[1];
    end
    function automatic logic [COORD_W-1:0] to_coord(input logic [2*Q_W-1:0] m,
                                                    input logic n);
        logic [2*Q_W-1:0] r;
        logic [2*Q_W-1:0] cap;
        r   = (m + (62'd1 << (59 - COORD_FRAC_BITS))) >> (60 - COORD_FRAC_BITS);
        cap = 62'd1 << COORD_FRAC_BITS;
        if (r > cap) r = cap;
        return n ? COORD_W'(62'd0 - r) : COORD_W'(r);
    endfunction

    side_t f;
    logic [TEX_W-1:0] tu_d [TEX_DLY], tv_d [TEX_DLY];
    always_ff @(posedge aclk) if (adv) begin
        tu_d[0] <= qn[2][ND][TEX_W-1:0]; tv_d[0] <= qn[3][ND][TEX_W-1:0];
        for (int i = 1; i < TEX_DLY; i++) begin
            tu_d[i] <= tu_d[i-1]; tv_d[i] <= tv_d[i-1];
        end
    end
    assign f = side_pipe[PIPE-2];
    logic [IDX_W-1:0] bl;
    assign bl = f.tl + IDX_W'(f.lon) + 21'd1;
    always_ff @(posedge aclk) if (adv) begin
        if (f.oor) begin
            m_axis_tdata <= '0;
            m_axis_tuser <= 2'b10;
        end else begin
            m_axis_tdata[15:0]    <= to_coord(px, nx);
            m_axis_tdata[31:16]   <= to_coord(py, ny);
            m_axis_tdata[47:32]   <= to_coord(pz, nz);
            m_axis_tdata[64:48]   <= tu_d[TEX_DLY-1];
            m_axis_tdata[81:65]   <= tv_d[TEX_DLY-1];
            m_axis_tdata[102:82]  <= f.quad ? f.tl : '0;
            m_axis_tdata[123:103] <= f.quad ? f.tl + 21'd1 : '0;
            m_axis_tdata[144:124] <= f.quad ? bl : '0;
            m_axis_tdata[165:145] <= f.quad ? bl + 21'd1 : '0;
            m_axis_tdata[167:166] <= '0;
            m_axis_tuser <= {1'b0, f.quad};
        end
    end

    ap_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg)) else $error("pipe moved");
    ap_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1])) else $error("flags");
    ap_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0)) else $error("oor");
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for uv_sphere_tessellator: it drives grid points, predicts
// each vertex in a scoreboard class and compares every output beat against the prediction.
// Depends on the RTL package uvs_pkg and the top level uv_sphere_tessellator.
`timescale 1ns / 1ps

module testbench;
    import uvs_pkg::*;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pos_z;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic        has_quad;
        logic [20:0] idx_tl;
        logic [20:0] idx_tr;
        logic [20:0] idx_bl;
        logic [20:0] idx_br;
        logic        out_of_range;
    } vertex_t;

    class tess_scoreboard;
        logic [10:0] lat_reg = 11'd16;
        logic [10:0] lon_reg = 11'd32;
        vertex_t     pending[$];
        int          mismatches = 0;
        int          checked = 0;

        function void write_reg(logic [10:0] addr, logic [10:0] data);
            if (addr == REG_LAT) lat_reg = data;
            else if (addr == REG_LON) lon_reg = data;
        endfunction

        function longint unsigned clamp_count(logic [10:0] v);
            if (v < 1) return 1;
            if (v > MAX_SEGMENTS_DEF) return MAX_SEGMENTS_DEF;
            return v;
        endfunction

        // sin(pi/2 * x), x in Q30, Horner on x^2 with truncating products
        function longint unsigned quarter_sine(longint unsigned x);
            longint unsigned x2, p, s;
            x2 = (x * x) >> 30;
            p = COEF4;
            p = COEF3 - ((p * x2) >> 30);
            p = COEF2 - ((p * x2) >> 30);
            p = COEF1 - ((p * x2) >> 30);
            p = COEF0 - ((p * x2) >> 30);
            s = (p * x) >> 30;
            return (s > (64'd1 << 30)) ? (64'd1 << 30) : s;
        endfunction

        function longint unsigned turn_sine(logic [31:0] phase, output bit neg);
            longint unsigned frac, x, s;
            frac = phase[29:0];
            x = phase[30] ? ((64'd1 << 30) - frac) : frac;
            s = quarter_sine(x);
            neg = phase[31] && (s != 0);
            return s;
        endfunction

        function logic [15:0] q60_to_coord(longint unsigned mag, bit neg);
            longint unsigned r;
            r = (mag + (64'd1 << (59 - COORD_FRAC_BITS_DEF))) >> (60 - COORD_FRAC_BITS_DEF);
            if (r > (64'd1 << COORD_FRAC_BITS_DEF)) r = 64'd1 << COORD_FRAC_BITS_DEF;
            return neg ? 16'(64'd0 - r) : 16'(r);
        endfunction

        function void note_point(logic [10:0] row_in, logic [10:0] col_in);
            vertex_t v;
            longint unsigned lat, lon, row, col, st, ct, sp, cp, tl, bl;
            logic [31:0] ph_t, ph_p;
            bit nst, nct, nsp, ncp;
            lat = clamp_count(lat_reg);
            lon = clamp_count(lon_reg);
            row = row_in;
            col = col_in;
            v = '{default: '0};
            if (row > lat || col > lon) begin
                v.out_of_range = 1'b1;
            end else begin
                ph_t = 32'(((row << 32) + lat) / (2 * lat));
                ph_p = 32'(((col << 32) + (lon >> 1)) / lon);
                st = turn_sine(ph_t, nst);
                ct = turn_sine(ph_t + 32'h4000_0000, nct);
                sp = turn_sine(ph_p, nsp);
                cp = turn_sine(ph_p + 32'h4000_0000, ncp);
                v.pos_x = q60_to_coord(st * cp, nst != ncp);
                v.pos_y = q60_to_coord(ct << 30, nct);
                v.pos_z = q60_to_coord(st * sp, nst != nsp);
                v.tex_u = 17'((col * 65536 + (lon >> 1)) / lon);
                v.tex_v = 17'((row * 65536 + (lat >> 1)) / lat);
                if (row < lat && col < lon) begin
                    tl = row * (lon + 1) + col;
                    bl = tl + lon + 1;
                    v.has_quad = 1'b1;
                    v.idx_tl = 21'(tl);
                    v.idx_tr = 21'(tl + 1);
                    v.idx_bl = 21'(bl);
                    v.idx_br = 21'(bl + 1);
                end
            end
            pending = {pending, v};
        endfunction

        function void check_vertex(logic [167:0] tdata, logic [1:0] tuser);
            vertex_t got, exp_v;
            got.pos_x = tdata[15:0];
            got.pos_y = tdata[31:16];
            got.pos_z = tdata[47:32];
            got.tex_u = tdata[64:48];
            got.tex_v = tdata[81:65];
            got.idx_tl = tdata[102:82];
            got.idx_tr = tdata[123:103];
            got.idx_bl = tdata[144:124];
            got.idx_br = tdata[165:145];
            got.has_quad = tuser[0];
            got.out_of_range = tuser[1];
            checked++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected vertex beat: %p", got);
                return;
            end
            exp_v = pending.pop_front();
            if (got !== exp_v) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("vertex mismatch at %0t", $realtime);
                    $display("  expected %p", exp_v);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = '0;   // row[10:0], col[21:11], zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;        // pos_x, pos_y, pos_z, tex_u, tex_v, idx_tl..idx_br
    logic [1:0]   m_axis_tuser;        // has_quad, out_of_range
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [10:0]  cfg_addr = '0;
    logic [10:0]  cfg_data = '0;

    tess_scoreboard sb = new;
    int points_sent = 0;

    uv_sphere_tessellator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // output side: random backpressure, check each accepted beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_vertex(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= (pick_gap() == 0) || ($urandom_range(3) == 0);
        end
    end

    task automatic send_point(logic [10:0] row, logic [10:0] col, bit no_gap);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, col, row};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_point(row, col);
        points_sent++;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [10:0] addr, logic [10:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        sb.write_reg(addr, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_points(int count);
        logic [10:0] lat, lon, row, col;
        bit burst;
        lat = 11'(sb.clamp_count(sb.lat_reg));
        lon = 11'(sb.clamp_count(sb.lon_reg));
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 8) begin
                row = 11'($urandom_range(32'(lat)));
                col = 11'($urandom_range(32'(lon)));
            end else begin
                row = 11'($urandom);
                col = 11'($urandom);
            end
            burst = (i % 200) < 40;   // stretch without input gaps
            send_point(row, col, burst);
        end
    endtask

    logic [10:0] lat_set[8] = '{11'd16, 11'd1, 11'd1024, 11'd2047, 11'd7,
                                11'd100, 11'd3, 11'd0};
    logic [10:0] lon_set[8] = '{11'd32, 11'd1, 11'd1024, 11'd3, 11'd1500,
                                11'd200, 11'd5, 11'd2047};

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: poles, seam, grid edges, outside points
        send_point(0, 0, 0);
        send_point(16, 32, 0);
        send_point(8, 0, 0);
        send_point(0, 8, 0);
        send_point(16, 0, 0);
        send_point(4, 31, 0);
        send_point(15, 31, 0);
        send_point(17, 0, 0);
        send_point(0, 33, 0);
        send_point(11'h7FF, 11'h7FF, 0);
        send_point(1024, 1024, 0);
        drain();
        write_cfg(REG_LAT, 11'd1024);
        write_cfg(REG_LON, 11'd1024);
        send_point(1023, 1023, 1);
        send_point(1024, 1024, 1);
        send_point(512, 512, 1);
        send_point(1024, 0, 0);
        drain();
        // zero counts clamp to one; an unknown index is ignored
        write_cfg(REG_LAT, 11'd0);
        write_cfg(REG_LON, 11'd0);
        write_cfg(11'h7FF, 11'h7FF);
        send_point(0, 0, 0);
        send_point(1, 1, 0);
        send_point(2, 0, 0);
        send_point(0, 2, 0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_cfg(REG_LAT, lat_set[ph]);
            write_cfg(REG_LON, lon_set[ph]);
            random_points(140);
            drain();
        end

        repeat (30) @(posedge aclk);
        $display("covered %0d grid points over 11 register settings, %0d vertex beats checked",
                 points_sent, sb.checked);
        $display("settings included clamped counts, the 1024 maximum and out-of-grid points");
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d mismatches, %0d vertices missing", sb.mismatches, sb.pending.size());
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
